@@ hdl/rx_buffer_ring_owner_manager_defines.svh @@
// Assertion macros shared by the receive buffer ring manager.
`ifndef RX_BUFFER_RING_OWNER_MANAGER_DEFINES_SVH
`define RX_BUFFER_RING_OWNER_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBOM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBOM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rbom_pkg.sv @@
// Types, codes and constants of the receive buffer ring manager.
package rbom_pkg;

    // Ring length, ring pointers and the pool count are all 4 bits wide.
    localparam int PTR_W       = 4;
    localparam int LEN_W       = 16;
    localparam int MAX_RESULTS = 8;

    // Command codes carried in func
    localparam logic [2:0] FN_START  = 3'd0;
    localparam logic [2:0] FN_STOP   = 3'd1;
    localparam logic [2:0] FN_FILL   = 3'd2;
    localparam logic [2:0] FN_SCAN   = 3'd3;
    localparam logic [2:0] FN_ERROR  = 3'd4;
    localparam logic [2:0] FN_RETURN = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_ENABLE  = 2'd2;

    localparam logic [PTR_W-1:0] POOL_COUNT_RST      = 4'd8;
    localparam logic [LEN_W-1:0] BUFFER_CAPACITY_RST = 16'd1024;

    typedef enum logic [2:0] {
        KIND_ACK       = 3'd0,
        KIND_DELIVERED = 3'd1,
        KIND_INVALID   = 3'd2,
        KIND_OVERFLOW  = 3'd3,
        KIND_RESUME    = 3'd4,
        KIND_RESTART   = 3'd5,
        KIND_REJECTED  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0]       func;
        logic [2:0]       buf_index;
        logic [LEN_W-1:0] fill_len;
    } in_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [2:0]       out_index;
        logic [LEN_W-1:0] out_size;
        logic [3:0]       held_count;
        logic             flush_fifo;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_SCAN_CHK,
        ST_SCAN_EMIT,
        ST_WALK,
        ST_COUNT_OUT,
        ST_BACK_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  latch;
        logic  remount;
        logic  set_run;
        logic  clr_run;
        logic  set_ovf;
        logic  clr_ovf;
        logic  fill;
        logic  clr_idx;
        logic  scan_init;
        logic  mod_step;
        logic  scan_take;
        logic  scan_adv;
        logic  walk_init;
        logic  walk_step;
        logic  emit;
        kind_t kind;
        logic  emit_buf;
        logic  emit_cnt;
        logic  flush;
        logic  last;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       running;
        logic       overflowed;
        logic       pool_ok;
        logic       idx_ok;
        logic       owner_idx;
        logic       mod_done;
        logic       owner_b;
        logic       scan_last;
        logic       scan_disc;
        logic       walk_last;
        logic       cnt_zero;
    } ctl_status_t;

endpackage

@@ hdl/rx_buffer_ring_owner_manager.sv @@
// Top level of the receive buffer ring manager: controller, datapath and checks.
//
// A command is taken on a clock edge where start is high and busy is low.
// Every command yields one or more results, each shown on result for exactly
// one cycle with result_valid high; the receiver cannot stall, so each result
// is a transfer in the cycle it appears, and result.last marks the final one
// of the command. The first cycle after a transfer decodes the command; start,
// stop, fill, plain return and the rejected or acknowledged cases then show
// their single result in the following cycle, with busy already low, so
// another command can be taken while that result shows. A done scan first
// brings the scan point into the ring, subtracting the ring length while the
// point lies past its end, then checks the owner of each buffer and does the
// registered length read, at most 8 buffers per scan. A descriptor error, and
// a buffer return during overflow while running, walk the owner bits of the
// ring one per cycle before reporting. Owner bits sit in flip-flops and reset
// to DMA owned; lengths sit in a small RAM and carry no reset. Configuration
// is written through cfg_we/cfg_index/cfg_data and should change only while
// the block is idle.
module rx_buffer_ring_owner_manager #(
    parameter int POOL_SIZE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  rbom_pkg::in_item_t             item,
    output logic                           result_valid,
    output rbom_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [rbom_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbom_pkg::LEN_W-1:0]     cfg_data
);

`include "rx_buffer_ring_owner_manager_defines.svh"

    rbom_pkg::ctl_cmd_t    cmd;
    rbom_pkg::ctl_status_t status;

    // Sequence each transfer through decode, scan and walk
    rbom_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Hold ring state and drive the result register
    rbom_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // An accepted command keeps the block busy in the next cycle
    `RBOM_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "accepted command did not raise busy")

    // More results follow a non-final one, so the block stays busy
    `RBOM_ASSERT_IMP(a_more_busy, clk, rst_n, result_valid && !result.last, busy,
        "block idle while results of a command remain")

    // The final result frees the block
    `RBOM_ASSERT_IMP(a_last_idle, clk, rst_n, result_valid && result.last, !busy,
        "block still busy on final result")

    // Only delivered and discarded results carry a buffer
    `RBOM_ASSERT_IMP(a_buf_fields, clk, rst_n,
        result_valid && result.kind != rbom_pkg::KIND_DELIVERED &&
        result.kind != rbom_pkg::KIND_INVALID,
        result.out_index == 3'd0 && result.out_size == 16'd0,
        "buffer fields set on a result without a buffer")

endmodule

@@ hdl/rbom_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rbom_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/rbom_dp.sv @@
// Datapath: configuration, owner bits, length store, scan and walk pointers, result register.
module rbom_dp #(
    parameter int POOL_SIZE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbom_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbom_pkg::LEN_W-1:0]          cfg_data,
    input  rbom_pkg::in_item_t                  item,
    input  rbom_pkg::ctl_cmd_t                  cmd,
    output rbom_pkg::ctl_status_t               status,
    output rbom_pkg::result_t                   result,
    output logic                                result_valid
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int PTR_W = rbom_pkg::PTR_W;
    localparam int LEN_W = rbom_pkg::LEN_W;

    rbom_pkg::in_item_t    item_reg;
    logic [PTR_W-1:0]      pool_count_reg;
    logic [LEN_W-1:0]      capacity_reg;
    logic                  deliver_reg;
    logic [POOL_SIZE-1:0]  owner_reg;
    logic                  running_reg;
    logic                  ovf_reg;
    logic                  none_reg;
    logic [PTR_W-1:0]      last_reg;
    logic [PTR_W-1:0]      b_reg;
    logic [2:0]            step_reg;
    logic [PTR_W-1:0]      wp_reg;
    logic [PTR_W-1:0]      cnt_reg;
    rbom_pkg::result_t     result_reg;
    logic                  result_valid_reg;

    logic [PTR_W-1:0]      ring_n;
    logic [PTR_W-1:0]      b_inc;
    logic [PTR_W-1:0]      b_next;
    logic [PTR_W-1:0]      step_inc;
    logic [IDX_W-1:0]      idx_a;
    logic [IDX_W-1:0]      b_a;
    logic [IDX_W-1:0]      bn_a;
    logic [IDX_W-1:0]      wp_a;
    logic [LEN_W-1:0]      rd_len;
    logic                  disc;

    // Ring length: pool count clamped to 2..POOL_SIZE
    always_comb
    begin
        if (int'(pool_count_reg) > POOL_SIZE)
        begin
            ring_n = PTR_W'(POOL_SIZE);
        end
        else if (pool_count_reg < PTR_W'(2))
        begin
            ring_n = PTR_W'(2);
        end
        else
        begin
            ring_n = pool_count_reg;
        end
    end

    assign idx_a    = IDX_W'(item_reg.buf_index);
    assign b_a      = IDX_W'(b_reg);
    assign b_inc    = b_reg + PTR_W'(1);
    assign b_next   = (b_inc == ring_n) ? '0 : b_inc;
    assign bn_a     = IDX_W'(b_next);
    assign wp_a     = IDX_W'(wp_reg);
    assign step_inc = PTR_W'(step_reg) + PTR_W'(1);
    assign disc     = (rd_len == '0) || (rd_len > capacity_reg);

    always_comb
    begin
        status.func       = item_reg.func;
        status.running    = running_reg;
        status.overflowed = ovf_reg;
        status.pool_ok    = pool_count_reg >= PTR_W'(2);
        status.idx_ok     = PTR_W'(item_reg.buf_index) < ring_n;
        status.owner_idx  = owner_reg[idx_a];
        status.mod_done   = b_reg < ring_n;
        status.owner_b    = owner_reg[b_a];
        status.scan_last  = !((step_inc < ring_n) &&
                              (step_inc < PTR_W'(rbom_pkg::MAX_RESULTS)) &&
                              owner_reg[bn_a]);
        status.scan_disc  = disc;
        status.walk_last  = wp_reg == (ring_n - PTR_W'(1));
        status.cnt_zero   = cnt_reg == '0;
    end

    rbom_ram #(
        .WIDTH (LEN_W),
        .DEPTH (POOL_SIZE)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (cmd.fill),
        .wr_addr (idx_a),
        .wr_data (item_reg.fill_len),
        .rd_addr (b_a),
        .rd_data (rd_len)
    );

    // Captured item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count_reg <= rbom_pkg::POOL_COUNT_RST;
            capacity_reg   <= rbom_pkg::BUFFER_CAPACITY_RST;
            deliver_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbom_pkg::CFG_POOL_COUNT:      pool_count_reg <= cfg_data[PTR_W-1:0];
                rbom_pkg::CFG_BUFFER_CAPACITY: capacity_reg   <= cfg_data;
                rbom_pkg::CFG_DELIVER_ENABLE:  deliver_reg    <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // Ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg   <= '0;
            running_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            none_reg    <= 1'b1;
            last_reg    <= PTR_W'(POOL_SIZE - 1);
        end
        else
        begin
            if (cmd.set_run)
            begin
                running_reg <= 1'b1;
            end
            else if (cmd.clr_run)
            begin
                running_reg <= 1'b0;
            end

            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            else if (cmd.clr_ovf)
            begin
                ovf_reg <= 1'b0;
            end

            if (cmd.remount)
            begin
                owner_reg <= '0;
                none_reg  <= 1'b1;
                last_reg  <= PTR_W'(POOL_SIZE - 1);
            end
            else if (cmd.fill)
            begin
                owner_reg[idx_a] <= 1'b1;
            end
            else if (cmd.clr_idx)
            begin
                owner_reg[idx_a] <= 1'b0;
            end
            else if (cmd.scan_take)
            begin
                // hand back a bad length, or any buffer when delivery is off
                if (disc || !deliver_reg)
                begin
                    owner_reg[b_a] <= 1'b0;
                end
                last_reg <= b_reg;
                none_reg <= 1'b0;
            end
        end
    end

    // Scan pointer and walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg    <= '0;
            step_reg <= '0;
            wp_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                b_reg    <= none_reg ? '0 : last_reg + PTR_W'(1);
                step_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                b_reg <= b_reg - ring_n;
            end
            else if (cmd.scan_adv)
            begin
                b_reg    <= b_next;
                step_reg <= step_reg + 3'd1;
            end

            if (cmd.walk_init)
            begin
                wp_reg  <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                wp_reg  <= wp_reg + PTR_W'(1);
                cnt_reg <= cnt_reg + PTR_W'(owner_reg[wp_a]);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.kind       <= cmd.kind;
            result_reg.out_index  <= cmd.emit_buf ? 3'(b_reg) : 3'd0;
            result_reg.out_size   <= cmd.emit_buf ? rd_len : '0;
            result_reg.held_count <= cmd.emit_cnt ? 4'(cnt_reg) : 4'd0;
            result_reg.flush_fifo <= cmd.flush;
            result_reg.last       <= cmd.last;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ hdl/rbom_ctrl.sv @@
// Controller: sequences decode, scan and ring walks, and issues datapath commands.
module rbom_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rbom_pkg::ctl_status_t status,
    output rbom_pkg::ctl_cmd_t    cmd
);

    rbom_pkg::state_t state_reg;
    rbom_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != rbom_pkg::ST_IDLE;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbom_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rbom_pkg::ST_DECODE;
                end
            end
            rbom_pkg::ST_DECODE:
            begin
                state_next = rbom_pkg::ST_IDLE;
                case (status.func)
                    rbom_pkg::FN_SCAN:
                    begin
                        if (status.running)
                        begin
                            state_next = rbom_pkg::ST_MOD;
                        end
                    end
                    rbom_pkg::FN_ERROR:
                    begin
                        if (status.running && !status.overflowed)
                        begin
                            state_next = rbom_pkg::ST_WALK;
                        end
                    end
                    rbom_pkg::FN_RETURN:
                    begin
                        if (status.idx_ok && status.running && status.overflowed)
                        begin
                            state_next = rbom_pkg::ST_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            rbom_pkg::ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = rbom_pkg::ST_SCAN_CHK;
                end
            end
            rbom_pkg::ST_SCAN_CHK:
            begin
                state_next = status.owner_b ? rbom_pkg::ST_SCAN_EMIT : rbom_pkg::ST_IDLE;
            end
            rbom_pkg::ST_SCAN_EMIT:
            begin
                state_next = status.scan_last ? rbom_pkg::ST_IDLE : rbom_pkg::ST_SCAN_CHK;
            end
            rbom_pkg::ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = (status.func == rbom_pkg::FN_ERROR) ?
                                 rbom_pkg::ST_COUNT_OUT : rbom_pkg::ST_BACK_OUT;
                end
            end
            rbom_pkg::ST_COUNT_OUT: state_next = rbom_pkg::ST_IDLE;
            rbom_pkg::ST_BACK_OUT:  state_next = rbom_pkg::ST_IDLE;
            default:                state_next = rbom_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.kind = rbom_pkg::KIND_ACK;
        case (state_reg)
            rbom_pkg::ST_IDLE:
            begin
                cmd.latch = start;
            end
            rbom_pkg::ST_DECODE:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                case (status.func)
                    rbom_pkg::FN_START:
                    begin
                        if (status.running || !status.pool_ok)
                        begin
                            cmd.kind = rbom_pkg::KIND_REJECTED;
                        end
                        else
                        begin
                            cmd.set_run = 1'b1;
                            cmd.clr_ovf = 1'b1;
                            cmd.remount = 1'b1;
                            cmd.kind    = rbom_pkg::KIND_RESTART;
                        end
                    end
                    rbom_pkg::FN_STOP:
                    begin
                        cmd.clr_run = 1'b1;
                    end
                    rbom_pkg::FN_FILL:
                    begin
                        if (status.running && status.idx_ok && !status.owner_idx)
                        begin
                            cmd.fill = 1'b1;
                        end
                        else
                        begin
                            cmd.kind = rbom_pkg::KIND_REJECTED;
                        end
                    end
                    rbom_pkg::FN_SCAN:
                    begin
                        if (status.running)
                        begin
                            cmd.emit      = 1'b0;
                            cmd.last      = 1'b0;
                            cmd.scan_init = 1'b1;
                        end
                    end
                    rbom_pkg::FN_ERROR:
                    begin
                        if (status.running && !status.overflowed)
                        begin
                            cmd.emit      = 1'b0;
                            cmd.last      = 1'b0;
                            cmd.set_ovf   = 1'b1;
                            cmd.walk_init = 1'b1;
                        end
                    end
                    rbom_pkg::FN_RETURN:
                    begin
                        if (status.idx_ok)
                        begin
                            cmd.clr_idx = 1'b1;
                            if (status.running && status.overflowed)
                            begin
                                cmd.emit      = 1'b0;
                                cmd.last      = 1'b0;
                                cmd.walk_init = 1'b1;
                            end
                            else if (status.running)
                            begin
                                cmd.kind = rbom_pkg::KIND_RESUME;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            rbom_pkg::ST_MOD:
            begin
                cmd.mod_step = !status.mod_done;
            end
            rbom_pkg::ST_SCAN_CHK:
            begin
                // empty scan reports a single ack
                if (!status.owner_b)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                end
            end
            rbom_pkg::ST_SCAN_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_buf  = 1'b1;
                cmd.kind      = status.scan_disc ? rbom_pkg::KIND_INVALID :
                                                   rbom_pkg::KIND_DELIVERED;
                cmd.last      = status.scan_last;
                cmd.scan_take = 1'b1;
                cmd.scan_adv  = !status.scan_last;
            end
            rbom_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            rbom_pkg::ST_COUNT_OUT:
            begin
                cmd.emit     = 1'b1;
                cmd.last     = 1'b1;
                cmd.emit_cnt = 1'b1;
                cmd.kind     = rbom_pkg::KIND_OVERFLOW;
            end
            rbom_pkg::ST_BACK_OUT:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                if (status.cnt_zero)
                begin
                    cmd.clr_ovf = 1'b1;
                    cmd.remount = 1'b1;
                    cmd.flush   = 1'b1;
                    cmd.kind    = rbom_pkg::KIND_RESTART;
                end
            end
            default: ;
        endcase
    end

endmodule
